FILE: rtl/line_sensor_position_estimator_unit_defines.svh
// assertion macros for the line sensor position estimator
// used by line_sensor_position_estimator_unit.sv, expects aclk and aresetn in scope
`ifndef LINE_SENSOR_POSITION_ESTIMATOR_UNIT_DEFINES_SVH
`define LINE_SENSOR_POSITION_ESTIMATOR_UNIT_DEFINES_SVH

// plain property checked on every clock outside reset
`define LSPE_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define LSPE_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define LSPE_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lspe_pkg.sv
// shared types, constants and the sensor weight table of the position estimator
// no dependencies
package lspe_pkg;

    localparam int SENSORS     = 8;
    localparam int LIMIT_W     = 15;
    localparam int BLIND_W     = 8;
    localparam int WEIGHT_W    = 13;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_INDEX_W = 3;
    localparam int ERR_W       = 16;
    localparam int HIT_W       = 4;
    localparam int QUOT_W      = 15;

    localparam logic [LIMIT_W-1:0]  WINDOW_RESET = 15'd10240;
    localparam logic [LIMIT_W-1:0]  REOPEN_RESET = 15'd16384;
    localparam logic [LIMIT_W-1:0]  EDGE_RESET   = 15'd8192;
    localparam logic [LIMIT_W-1:0]  KICK_RESET   = 15'd11059;
    localparam logic [BLIND_W-1:0]  BLIND_RESET  = 8'd10;
    localparam logic [WEIGHT_W-1:0] EMA_RESET    = 13'd1638;
    localparam logic [WEIGHT_W-1:0] EMA_ONE      = 13'd4096;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REOPEN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KICK   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLIND  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_EMA    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_DIVIDE,
        ST_MULT,
        ST_FINISH
    } state_t;

    // q4.12 weight of sensor position, 0 is leftmost
    function automatic logic signed [ERR_W-1:0] sensor_weight(input logic [2:0] pos);
        logic signed [ERR_W-1:0] w;
        unique case (pos)
            3'd0: w = -16'sd8192;
            3'd1: w = -16'sd7373;
            3'd2: w = -16'sd6554;
            3'd3: w = -16'sd1229;
            3'd4: w = 16'sd1229;
            3'd5: w = 16'sd6554;
            3'd6: w = 16'sd7373;
            3'd7: w = 16'sd8192;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/line_sensor_position_estimator_unit.sv
// line sensor position estimator: windowed weighted centroid and exponential average
// depends on lspe_pkg and line_sensor_position_estimator_unit_defines.svh
// steps: scan of the eight sensors, decide, a bit-serial divide only when 1..7 sensors hit,
// multiply and finish; finish waits while an earlier result is still held unaccepted
// a new request is taken only in idle, once the previous result is in the output register
// reset: synchronous active low, restores register defaults, clears error and blind count
`include "line_sensor_position_estimator_unit_defines.svh"

module line_sensor_position_estimator_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [lspe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lspe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] sensor_bits
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata    // [15:0] position_error, [19:16] hit_count
);
    import lspe_pkg::*;

    state_t state_reg, state_next;

    logic [LIMIT_W-1:0]  window_reg, window_next;
    logic [LIMIT_W-1:0]  reopen_reg, reopen_next;
    logic [LIMIT_W-1:0]  edge_reg, edge_next;
    logic [LIMIT_W-1:0]  kick_reg, kick_next;
    logic [BLIND_W-1:0]  blind_lim_reg, blind_lim_next;
    logic [WEIGHT_W-1:0] ema_reg, ema_next;

    logic signed [ERR_W-1:0] last_error_reg, last_error_next;
    logic [BLIND_W-1:0]      blind_count_reg, blind_count_next;

    logic [7:0]              sensor_reg, sensor_next;
    logic [2:0]              idx_reg, idx_next;
    logic signed [ERR_W-1:0] sum_reg, sum_next;
    logic [HIT_W-1:0]        hits_reg, hits_next;
    logic [QUOT_W-1:0]       dq_reg, dq_next;
    logic [2:0]              rem_reg, rem_next;
    logic [3:0]              cnt_reg, cnt_next;
    logic signed [ERR_W-1:0] raw_reg, raw_next;
    logic signed [30:0]      prod_reg, prod_next;
    logic                    m_valid_reg, m_valid_next;
    logic [23:0]             m_data_reg, m_data_next;

    logic signed [16:0]      last17, last_abs, wt17, diff, diff_abs;
    logic signed [16:0]      edge17, kick17, raw17, delta;
    logic signed [ERR_W-1:0] wt;
    logic                    open_all, black, hit;
    logic [BLIND_W-1:0]      blind_inc;
    logic signed [ERR_W-1:0] sum_abs;
    logic [3:0]              trial;
    logic                    ge;
    logic [QUOT_W-1:0]       quot;
    logic signed [ERR_W-1:0] quot_s;
    logic [WEIGHT_W-1:0]     w_sat;
    logic signed [18:0]      shifted, next_err;
    logic signed [ERR_W-1:0] next_clamped;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        last17   = {last_error_reg[ERR_W-1], last_error_reg};
        last_abs = last17[16] ? -last17 : last17;
        open_all = $unsigned(last_abs) >= {2'b00, reopen_reg};
        wt       = sensor_weight(idx_reg);
        wt17     = {wt[ERR_W-1], wt};
        diff     = wt17 - last17;
        diff_abs = diff[16] ? -diff : diff;
        black    = !sensor_reg[3'd7 - idx_reg];
        hit      = black && (open_all || ($unsigned(diff_abs) <= {2'b00, window_reg}));

        edge17    = $signed({2'b00, edge_reg});
        kick17    = $signed({2'b00, kick_reg});
        blind_inc = (blind_count_reg == '1) ? blind_count_reg : blind_count_reg + 8'd1;
        sum_abs   = sum_reg[ERR_W-1] ? -sum_reg : sum_reg;

        trial  = {rem_reg, dq_reg[QUOT_W-1]};
        ge     = trial >= {1'b0, hits_reg[2:0]};
        quot   = {dq_reg[QUOT_W-2:0], ge};
        quot_s = $signed({1'b0, quot});

        w_sat   = (ema_reg > EMA_ONE) ? EMA_ONE : ema_reg;
        raw17   = {raw_reg[ERR_W-1], raw_reg};
        delta   = raw17 - last17;
        shifted = 19'(prod_reg >>> 12);
        next_err = {{3{last_error_reg[ERR_W-1]}}, last_error_reg} + shifted;
        if (next_err > 19'sd32767) begin
            next_clamped = 16'sd32767;
        end else if (next_err < -19'sd32768) begin
            next_clamped = -16'sd32768;
        end else begin
            next_clamped = next_err[ERR_W-1:0];
        end
    end

    always_comb begin
        state_next       = state_reg;
        window_next      = window_reg;
        reopen_next      = reopen_reg;
        edge_next        = edge_reg;
        kick_next        = kick_reg;
        blind_lim_next   = blind_lim_reg;
        ema_next         = ema_reg;
        last_error_next  = last_error_reg;
        blind_count_next = blind_count_reg;
        sensor_next      = sensor_reg;
        idx_next         = idx_reg;
        sum_next         = sum_reg;
        hits_next        = hits_reg;
        dq_next          = dq_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        raw_next         = raw_reg;
        prod_next        = prod_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                REG_WINDOW: window_next    = cfg_wdata[LIMIT_W-1:0];
                REG_REOPEN: reopen_next    = cfg_wdata[LIMIT_W-1:0];
                REG_EDGE:   edge_next      = cfg_wdata[LIMIT_W-1:0];
                REG_KICK:   kick_next      = cfg_wdata[LIMIT_W-1:0];
                REG_BLIND:  blind_lim_next = cfg_wdata[BLIND_W-1:0];
                REG_EMA:    ema_next       = cfg_wdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sensor_next = s_tdata;
                    idx_next    = '0;
                    sum_next    = '0;
                    hits_next   = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    sum_next  = sum_reg + wt;
                    hits_next = hits_reg + 4'd1;
                end
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd7) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (hits_reg == 4'd0) begin
                    blind_count_next = blind_inc;
                    if (blind_inc <= blind_lim_reg) begin
                        if (last17 > edge17) begin
                            raw_next = kick17[ERR_W-1:0];
                        end else if (last17 < -edge17) begin
                            raw_next = -kick17[ERR_W-1:0];
                        end else begin
                            raw_next = last_error_reg;
                        end
                    end else begin
                        if (last17 > 17'sd0) begin
                            raw_next = kick17[ERR_W-1:0];
                        end else if (last17 < 17'sd0) begin
                            raw_next = -kick17[ERR_W-1:0];
                        end else begin
                            raw_next = '0;
                        end
                    end
                    state_next = ST_MULT;
                end else if (hits_reg == 4'd8) begin
                    blind_count_next = '0;
                    raw_next         = last_error_reg;
                    state_next       = ST_MULT;
                end else begin
                    blind_count_next = '0;
                    dq_next          = sum_abs[QUOT_W-1:0];
                    rem_next         = '0;
                    cnt_next         = '0;
                    state_next       = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                rem_next = ge ? 3'(trial - {1'b0, hits_reg[2:0]}) : trial[2:0];
                dq_next  = quot;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(QUOT_W - 1)) begin
                    raw_next   = sum_reg[ERR_W-1] ? -quot_s : quot_s;
                    state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                prod_next  = 31'(delta) * 31'($signed({1'b0, w_sat}));
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    last_error_next = next_clamped;
                    m_data_next     = {4'd0, hits_reg, next_clamped};
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            window_reg      <= WINDOW_RESET;
            reopen_reg      <= REOPEN_RESET;
            edge_reg        <= EDGE_RESET;
            kick_reg        <= KICK_RESET;
            blind_lim_reg   <= BLIND_RESET;
            ema_reg         <= EMA_RESET;
            last_error_reg  <= '0;
            blind_count_reg <= '0;
            m_valid_reg     <= 1'b0;
            hits_reg        <= '0;
            idx_reg         <= '0;
            cnt_reg         <= '0;
        end else begin
            state_reg       <= state_next;
            window_reg      <= window_next;
            reopen_reg      <= reopen_next;
            edge_reg        <= edge_next;
            kick_reg        <= kick_next;
            blind_lim_reg   <= blind_lim_next;
            ema_reg         <= ema_next;
            last_error_reg  <= last_error_next;
            blind_count_reg <= blind_count_next;
            m_valid_reg     <= m_valid_next;
            hits_reg        <= hits_next;
            idx_reg         <= idx_next;
            cnt_reg         <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        sensor_reg <= sensor_next;
        sum_reg    <= sum_next;
        dq_reg     <= dq_next;
        rem_reg    <= rem_next;
        raw_reg    <= raw_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    `LSPE_CHECK(a_hits_range, hits_reg <= 4'd8, "hit count above sensor count")
    `LSPE_IMPLY(a_div_hits, state_reg == ST_DIVIDE, hits_reg != 4'd0 && hits_reg != 4'd8,
        "divider running without a valid divisor")
    `LSPE_NEXT(a_req_scan, s_tvalid && s_tready, state_reg == ST_SCAN,
        "accepted request did not start the scan")
    `LSPE_IMPLY(a_load_finish, $rose(m_valid_reg), $past(state_reg) == ST_FINISH,
        "result loaded outside finish step")

endmodule

FILE: tb/tb.sv
// self-checking testbench for line_sensor_position_estimator_unit
// holds its own model of the windowed centroid and smoothing filter, drives random
// stream traffic with idles on both sides; depends on lspe_pkg and the rtl top
module tb;
    import lspe_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic [HIT_W-1:0]        hits;
    } track_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [23:0]            m_tdata;

    // model copy of registers and state
    logic [LIMIT_W-1:0]      window_lim;
    logic [LIMIT_W-1:0]      reopen_lim;
    logic [LIMIT_W-1:0]      edge_lim;
    logic [LIMIT_W-1:0]      kick_mag;
    logic [BLIND_W-1:0]      blind_lim;
    logic [WEIGHT_W-1:0]     ema_w;
    logic signed [ERR_W-1:0] last_err;
    logic [BLIND_W-1:0]      blind_cnt;

    int lane_weight [0:7] = '{-8192, -7373, -6554, -1229, 1229, 6554, 7373, 8192};

    track_result_t pending_track[$];
    int samples_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    bit send_eager = 1'b0;
    bit take_eager = 1'b0;
    int line_pos = 3;
    int white_left = 0;

    always #5 aclk = ~aclk;

    line_sensor_position_estimator_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] sensor_bits
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // [15:0] position_error, [19:16] hit_count
    );

    function automatic track_result_t estimate_position(input logic [7:0] bits);
        track_result_t res;
        int last, sum, hits, raw, lane_gap, nxt, wt;
        int win_i, reo_i, edge_i, kick_i, mag;
        longint acc;
        bit window_open;
        last = last_err;
        win_i = window_lim;
        reo_i = reopen_lim;
        edge_i = edge_lim;
        kick_i = kick_mag;
        mag = (last < 0) ? -last : last;
        window_open = (mag >= reo_i);
        sum = 0;
        hits = 0;
        for (int i = 0; i < 8; i++) begin
            if (!bits[7-i]) begin
                lane_gap = lane_weight[i] - last;
                if (lane_gap < 0) lane_gap = -lane_gap;
                if (window_open || lane_gap <= win_i) begin
                    hits++;
                    sum += lane_weight[i];
                end
            end
        end
        if (hits >= 1 && hits <= 7) begin
            blind_cnt = '0;
            raw = sum / hits;
        end else if (hits == 8) begin
            blind_cnt = '0;
            raw = last;
        end else begin
            if (blind_cnt != 8'hFF) blind_cnt = blind_cnt + 8'd1;
            if (blind_cnt <= blind_lim) begin
                if (last > edge_i) raw = kick_i;
                else if (last < -edge_i) raw = -kick_i;
                else raw = last;
            end else begin
                if (last > 0) raw = kick_i;
                else if (last < 0) raw = -kick_i;
                else raw = 0;
            end
        end
        wt = (ema_w > EMA_ONE) ? 4096 : int'(ema_w);
        acc = longint'(raw) * wt + longint'(last) * (4096 - wt);
        nxt = int'(acc >>> 12);
        if (nxt > 32767) nxt = 32767;
        if (nxt < -32768) nxt = -32768;
        last_err = nxt[ERR_W-1:0];
        res.err = nxt[ERR_W-1:0];
        res.hits = hits[HIT_W-1:0];
        return res;
    endfunction

    // mostly a drifting line, with line loss bursts, all black and noise mixed in
    function automatic logic [7:0] next_sample();
        logic [7:0] bits;
        int pick, span;
        bits = 8'hFF;
        if (white_left > 0) begin
            white_left--;
            return bits;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) return 8'($urandom_range(0, 255));
        if (pick < 13) begin
            white_left = $urandom_range(0, 40);
            return bits;
        end
        if (pick < 15) return 8'h00;
        line_pos = line_pos + $urandom_range(0, 2) - 1;
        if (line_pos < 0) line_pos = 0;
        if (line_pos > 7) line_pos = 7;
        span = $urandom_range(1, 3);
        for (int i = 0; i < span; i++) begin
            if (line_pos + i <= 7) bits[7-(line_pos+i)] = 1'b0;
        end
        if (pick < 25) bits[$urandom_range(0, 7)] ^= 1'b1;
        return bits;
    endfunction

    task automatic send_sample(input logic [7:0] bits);
        int gap;
        if ($urandom_range(0, 49) == 0) send_eager = !send_eager;
        gap = send_eager ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= bits;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_track.push_back(estimate_position(bits));
        samples_sent++;
    endtask

    // block must be idle: no request held, every result back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_track.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_WINDOW: window_lim = val[LIMIT_W-1:0];
            REG_REOPEN: reopen_lim = val[LIMIT_W-1:0];
            REG_EDGE:   edge_lim = val[LIMIT_W-1:0];
            REG_KICK:   kick_mag = val[LIMIT_W-1:0];
            REG_BLIND:  blind_lim = val[BLIND_W-1:0];
            REG_EMA:    ema_w = val[WEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_all(input logic [CFG_DATA_W-1:0] win, reo, edg, kck, bln, ema);
        write_reg(REG_WINDOW, win);
        write_reg(REG_REOPEN, reo);
        write_reg(REG_EDGE, edg);
        write_reg(REG_KICK, kck);
        write_reg(REG_BLIND, bln);
        write_reg(REG_EMA, ema);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_traffic(input int count);
        for (int i = 0; i < count; i++) send_sample(next_sample());
        settle();
    endtask

    task automatic test_directed_cases();
        // reset values: line lost, all black, each sensor alone, pairs
        send_sample(8'hFF);
        send_sample(8'h00);
        for (int k = 7; k >= 0; k--) send_sample(~(8'h01 << k));
        send_sample(8'hE7);
        send_sample(8'h3C);
        settle();
        // zero window, always open, hard kick, weight above one
        program_all(15'd0, 15'd0, 15'd0, 15'd32767, 15'd0, 15'd8191);
        send_sample(8'h7F);
        send_sample(8'hFF);
        send_sample(8'h00);
        send_sample(8'hFE);
        send_sample(8'hFF);
        settle();
        // writes past the register list are dropped
        write_reg(REG_SPARE_LO, 15'h7FFF);
        write_reg(REG_SPARE_HI, 15'h5555);
        program_all(15'd32767, 15'd32767, 15'd32767, 15'd0, 15'd255, 15'd0);
        send_sample(8'h55);
        send_sample(8'hAA);
        settle();
    endtask

    task automatic test_default_tracking();
        program_all(WINDOW_RESET, REOPEN_RESET, EDGE_RESET, KICK_RESET,
                    CFG_DATA_W'(BLIND_RESET), CFG_DATA_W'(EMA_RESET));
        run_traffic(300);
    endtask

    task automatic test_random_settings();
        logic [CFG_DATA_W-1:0] ema;
        for (int p = 0; p < 5; p++) begin
            if ($urandom_range(0, 3) == 0) ema = 15'($urandom_range(0, 32767));
            else ema = 15'($urandom_range(1, 4096));
            program_all(15'($urandom_range(0, 16384)), 15'($urandom_range(0, 32767)),
                        15'($urandom_range(0, 9000)), 15'($urandom_range(0, 32767)),
                        15'($urandom_range(0, 40)), ema);
            run_traffic(80);
        end
    endtask

    task automatic test_extreme_settings();
        program_all(15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0);
        run_traffic(70);
        program_all(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        run_traffic(70);
        program_all(15'd0, 15'd32767, 15'd0, 15'd32767, 15'd0, 15'd4096);
        run_traffic(70);
    endtask

    task automatic test_blind_saturation();
        // a wrapping counter would fall back under the limit and hold the error
        program_all(15'd32767, 15'd32767, 15'd32767, 15'd32767, 15'd254, 15'd2048);
        repeat (3) send_sample(8'h7F);
        repeat (262) send_sample(8'hFF);
        send_sample(8'hFE);
        repeat (3) send_sample(8'hFF);
        settle();
    endtask

    initial begin : result_sink
        track_result_t want;
        logic signed [ERR_W-1:0] got_err;
        logic [HIT_W-1:0] got_hits;
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if ($urandom_range(0, 49) == 0) take_eager = !take_eager;
            stall = take_eager ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got_err = m_tdata[15:0];
            got_hits = m_tdata[19:16];
            results_checked++;
            if (pending_track.size() == 0) begin
                $display("%0t: unexpected result, expected none got err %0d hits %0d",
                         $time, got_err, got_hits);
                mismatch_count++;
            end else begin
                want = pending_track.pop_front();
                if (got_err !== want.err) begin
                    $display("%0t: position_error expected %0d got %0d",
                             $time, want.err, got_err);
                    mismatch_count++;
                end
                if (got_hits !== want.hits) begin
                    $display("%0t: hit_count expected %0d got %0d",
                             $time, want.hits, got_hits);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'hFF;
        window_lim = WINDOW_RESET;
        reopen_lim = REOPEN_RESET;
        edge_lim = EDGE_RESET;
        kick_mag = KICK_RESET;
        blind_lim = BLIND_RESET;
        ema_w = EMA_RESET;
        last_err = '0;
        blind_cnt = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_default_tracking();
        test_random_settings();
        test_extreme_settings();
        test_blind_saturation();
        $display("sent %0d sensor samples over reset, random, extreme and saturated settings",
                 samples_sent);
        $display("checked %0d results, %0d field mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_track.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("timeout with %0d results outstanding", pending_track.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/lspe_pkg.sv
rtl/line_sensor_position_estimator_unit.sv
tb/tb.sv
